>>> rtl/adq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adq_pkg
// Shared types and codes for the array deque: request and response payloads,
// operation and status codes, and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package adq_pkg;

   localparam int unsigned DATA_W = 32;

   typedef enum logic [1:0] {
      KIND_INS_FRONT = 2'd0,
      KIND_INS_REAR  = 2'd1,
      KIND_DEL_REAR  = 2'd2,
      KIND_DEL_FRONT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic signed [DATA_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] value_out;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic exec;
      logic post;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

>>> rtl/array_deque_unit.sv
`timescale 1ns / 1ps
// A request is latched on accept, applied to the deque in the update step and
// then loaded into the output register, later if the previous response is still
// stalled there. No new request is accepted until that load is done, so each
// request runs the accept, update and output-load steps of the sequencer.
// Reset: synchronous; the deque comes up empty with both indices at slot 0.
// ----------------------------------------------------------------------------
// array_deque_unit
// Double-ended queue over a non-wrapping array, one response per request.
// ----------------------------------------------------------------------------
module array_deque_unit #(
   parameter int unsigned DEPTH = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  adq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output adq_pkg::rsp_type rsp_data
);
   import adq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   adq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   adq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/adq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adq_ctrl
// Sequencer for the deque: takes a request, runs the update step, then
// hands the result to the output register once that register is free.
// ----------------------------------------------------------------------------
module adq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  adq_pkg::stat_type stat,
   output adq_pkg::cmd_type  cmd
);
   import adq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_POST = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.load_req = 1'b0;
      cmd.exec     = 1'b0;
      cmd.post     = 1'b0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_POST;
         end
         ST_POST: begin
            // Wait here while an earlier response is still held downstream.
            if (stat.out_free) begin
               cmd.post = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/adq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adq_dpath
// Deque datapath: element memory, head and tail indices, empty flag,
// request latch and the response output register.
// ----------------------------------------------------------------------------
module adq_dpath #(
   parameter int unsigned DEPTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  adq_pkg::req_type  req_data,
   input  adq_pkg::cmd_type  cmd,
   output adq_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output adq_pkg::rsp_type  rsp_data
);
   import adq_pkg::*;

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   logic [DATA_W-1:0] mem [DEPTH];

   logic [1:0]        kind_ff;
   logic [DATA_W-1:0] value_ff;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic              empty_ff, empty_in;
   logic [1:0]        status_ff, status_in;
   logic              del_ok_ff, del_ok_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [IDX_W-1:0]  rd_addr;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      status_in = STATUS_OK;
      del_ok_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      rd_addr   = (kind_ff == KIND_DEL_REAR) ? tail_ff : head_ff;
      case (kind_ff)
         KIND_INS_FRONT: begin
            if (empty_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
               wr_en    = 1'b1;
            end else if (head_ff == '0) begin
               status_in = STATUS_FULL;
            end else begin
               head_in = head_ff - 1'b1;
               wr_addr = head_ff - 1'b1;
               wr_en   = 1'b1;
            end
         end
         KIND_INS_REAR: begin
            if (empty_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
               wr_en    = 1'b1;
            end else if (tail_ff == LAST_IDX) begin
               status_in = STATUS_FULL;
            end else begin
               tail_in = tail_ff + 1'b1;
               wr_addr = tail_ff + 1'b1;
               wr_en   = 1'b1;
            end
         end
         KIND_DEL_REAR: begin
            if (empty_ff) begin
               status_in = STATUS_EMPTY;
            end else begin
               del_ok_in = 1'b1;
               if (head_ff == tail_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else begin
                  tail_in = tail_ff - 1'b1;
               end
            end
         end
         KIND_DEL_FRONT: begin
            if (empty_ff) begin
               status_in = STATUS_EMPTY;
            end else begin
               del_ok_in = 1'b1;
               if (head_ff == tail_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else begin
                  head_in = head_ff + 1'b1;
               end
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   // Element memory: at most one write and one registered read per cycle, both only in the update step.
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (cmd.exec) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff  <= req_data.kind;
         value_ff <= req_data.value_in;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         del_ok_ff <= del_ok_in;
      end
      if (cmd.post) begin
         rsp_ff.status    <= status_ff;
         rsp_ff.value_out <= del_ok_ff ? rd_data_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            empty_ff <= empty_in;
         end
         if (cmd.post) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

endmodule

>>> verif/array_deque_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_deque_unit_tb
// Self-checking bench for the array deque. A queue-fed driver offers requests
// and a monitor predicts each response from its own copy of the deque,
// checking status and removed value in order, under random sender gaps and
// receiver stalls, a long receiver hold-off and full drains between phases.
// ----------------------------------------------------------------------------
module array_deque_unit_tb;
   import adq_pkg::*;

   localparam int unsigned DEQ_DEPTH = 128;
   localparam int          CYCLE_LIMIT = 300000;
   localparam int          PHASE_ITEMS = 235;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   int req_issued = 0;
   int req_accepted = 0;
   int snd_idle_pct = 10;
   int rcv_idle_pct = 56;
   int hold_len = 0;
   int fail_count = 0;
   int cycle_count = 0;

   // Predicted deque contents.
   logic signed [DATA_W-1:0] dq_slots [DEQ_DEPTH];
   int unsigned              dq_head = 0;
   int unsigned              dq_tail = 0;
   logic                     dq_empty = 1'b1;

   array_deque_unit #(
      .DEPTH(DEQ_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic rsp_type deque_apply(req_type r);
      rsp_type res;
      res.status    = STATUS_OK;
      res.value_out = '0;
      case (kind_type'(r.kind))
         KIND_INS_FRONT, KIND_INS_REAR: begin
            if (dq_empty) begin
               dq_head     = 0;
               dq_tail     = 0;
               dq_slots[0] = r.value_in;
               dq_empty    = 1'b0;
            end else if (r.kind == KIND_INS_FRONT) begin
               if (dq_head == 0) begin
                  res.status = STATUS_FULL;
               end else begin
                  dq_head--;
                  dq_slots[dq_head] = r.value_in;
               end
            end else if (dq_tail >= DEQ_DEPTH - 1) begin
               res.status = STATUS_FULL;
            end else begin
               dq_tail++;
               dq_slots[dq_tail] = r.value_in;
            end
         end
         default: begin
            if (dq_empty) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.value_out = (r.kind == KIND_DEL_REAR) ? dq_slots[dq_tail]
                                                         : dq_slots[dq_head];
               // Taking the last element leaves the deque empty at slot 0.
               if (dq_head == dq_tail) begin
                  dq_head  = 0;
                  dq_tail  = 0;
                  dq_empty = 1'b1;
               end else if (r.kind == KIND_DEL_REAR) begin
                  dq_tail--;
               end else begin
                  dq_head++;
               end
            end
         end
      endcase
      return res;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_req(kind_type k, logic signed [DATA_W-1:0] v);
      req_type r;
      r.kind     = k;
      r.value_in = v;
      pending_reqs.push_back(r);
   endtask

   task automatic push_run(kind_type k, int count);
      repeat (count) push_req(k, pick_value());
   endtask

   // Runs of one kind move the indices far enough to reach both full ends
   // and to empty the deque; short mixed runs add noise.
   task automatic gen_random(int n_items);
      int       total;
      int       count;
      kind_type k;
      bit       mixed;
      total = 0;
      while (total < n_items) begin
         k     = KIND_INS_REAR;
         mixed = 1'b0;
         case ($urandom_range(7))
            0: begin
               count = 140;
            end
            1, 2: begin
               count = $urandom_range(1, 40);
            end
            3: begin
               k     = KIND_DEL_FRONT;
               count = $urandom_range(1, 60);
            end
            4: begin
               k     = KIND_INS_FRONT;
               count = $urandom_range(1, 8);
            end
            5: begin
               k     = KIND_DEL_REAR;
               count = $urandom_range(1, 60);
            end
            default: begin
               mixed = 1'b1;
               count = $urandom_range(1, 16);
            end
         endcase
         // The last run is cut short so the phase has the requested size.
         if (count > n_items - total) begin
            count = n_items - total;
         end
         if (mixed) begin
            repeat (count) push_req(kind_type'($urandom_range(3)), pick_value());
         end else begin
            push_run(k, count);
         end
         total += count;
      end
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_issued != req_accepted ||
             expected_rsps.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Request driver.
   always @(negedge clock) begin
      // A stalled request stays on the bus unchanged.
      if (!reset && !(req_valid && req_accepted != req_issued)) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_issued++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response receiver.
   always @(negedge clock) begin
      if (hold_len > 0) begin
         rsp_stall <= 1'b1;
         hold_len--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // Monitor: checks responses, then predicts for newly accepted requests.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response: status %0d value_out %0d",
                      rsp_data.status, rsp_data.value_out);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.value_out !== want.value_out) begin
                  $error("value_out: expected %0d, got %0d",
                         want.value_out, rsp_data.value_out);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(deque_apply(req_data));
            req_accepted++;
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL array_deque_unit");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty deletes, inserts into an empty deque, both full-at-front cases,
      // last element taken from either end, and the value extremes.
      push_req(KIND_DEL_REAR, pick_value());
      push_req(KIND_DEL_FRONT, pick_value());
      push_req(KIND_INS_FRONT, 32'sh7FFF_FFFF);
      push_req(KIND_INS_FRONT, 32'sd5);
      push_req(KIND_DEL_FRONT, pick_value());
      push_req(KIND_DEL_REAR, pick_value());
      push_req(KIND_INS_REAR, 32'sh8000_0000);
      push_req(KIND_INS_REAR, -32'sd1);
      push_req(KIND_INS_REAR, 32'sd0);
      push_req(KIND_DEL_FRONT, pick_value());
      push_req(KIND_INS_FRONT, 32'sh5555_5555);
      push_req(KIND_INS_FRONT, 32'sd7);
      push_req(KIND_DEL_REAR, pick_value());
      push_req(KIND_DEL_REAR, pick_value());
      push_req(KIND_DEL_REAR, pick_value());
      push_req(KIND_DEL_REAR, pick_value());
      push_req(KIND_INS_REAR, 32'shAAAA_AAAA);
      push_req(KIND_DEL_FRONT, pick_value());
      push_req(KIND_INS_FRONT, 32'sd1);
      push_req(KIND_INS_REAR, 32'sd2);
      push_req(KIND_DEL_FRONT, pick_value());
      push_req(KIND_DEL_FRONT, pick_value());
      wait_drained();

      gen_random(PHASE_ITEMS);
      wait_drained();

      snd_idle_pct = 56;
      rcv_idle_pct = 10;
      gen_random(PHASE_ITEMS);
      wait_drained();

      // The receiver holds off while the sender keeps offering a full run of
      // rear inserts, so the block backs up and stalls its input.
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      push_run(KIND_INS_REAR, 140);
      hold_len = 400;
      gen_random(PHASE_ITEMS - 140);
      wait_drained();

      repeat (20) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS array_deque_unit");
      end else begin
         $display("FAIL array_deque_unit");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/adq_pkg.sv
rtl/adq_ctrl.sv
rtl/adq_dpath.sv
rtl/array_deque_unit.sv
verif/array_deque_unit_tb.sv
